/* rtl/core/mme_pkg.sv */
// Shared types and constants for the matrix multiply engine.
// Used by the cell row, the top level and the port checker; no dependencies.
package mme_pkg;

	// Width of an element, of a row or column field, and of the accumulator.
	localparam int ELEM_W    = 16;
	localparam int FIELD_W   = 3;
	localparam int ACC_W     = 36;
	localparam int PROD_W    = 2 * ELEM_W;
	localparam int DIM_REG_W = 4;

	// Default and largest supported matrix dimension.
	localparam int MAX_DIM_DEFAULT = 8;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 48;

	// Function codes of an input beat.
	localparam logic [1:0] FUNC_LOAD_A = 2'd0;
	localparam logic [1:0] FUNC_LOAD_B = 2'd1;
	localparam logic [1:0] FUNC_START  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_A_ROWS = 2'd0;
	localparam logic [1:0] REG_A_COLS = 2'd1;
	localparam logic [1:0] REG_B_ROWS = 2'd2;
	localparam logic [1:0] REG_B_COLS = 2'd3;

	localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

	// One A element travelling down the cell row with its inner index.
	typedef struct packed {
		logic                     valid;
		logic                     first;
		logic                     last;
		logic [FIELD_W-1:0]       k;
		logic signed [ELEM_W-1:0] a;
	} tok_t;

	// Write of one B element into the column store of a cell.
	typedef struct packed {
		logic [FIELD_W-1:0]       row;
		logic signed [ELEM_W-1:0] data;
	} bwr_t;

endpackage

/* rtl/core/matrix_multiply_engine_top.sv */
// Matrix multiply engine: load A/B elements, then stream A x B in row-major order.
// A start computes C one row at a time: the row's A elements enter a chain of MAX_DIM
// cells, one per cycle; once the last cell has finished the row, its b_cols results are
// drained, each as the output register frees. A size mismatch at the start yields a
// single error beat instead. Reset idles control, sets dimensions to 8, keeps stores.
module matrix_multiply_engine_top #(
	parameter int MAX_DIM = mme_pkg::MAX_DIM_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration write port.
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [mme_pkg::DIM_REG_W-1:0]    cfg_data,
	// Input stream: func, elem_row, elem_col, elem_value.
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [mme_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// Output stream: out_row, out_col, product_value, zero pad.
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [mme_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output logic                             m_axis_tlast,
	// size_error.
	output logic                             m_axis_tuser
);

	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int AW    = 2 * IDX_W;
	localparam int PAD_W = mme_pkg::OUT_TDATA_W - 2 * mme_pkg::FIELD_W - mme_pkg::ACC_W;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_FEED  = 5'b00010,
		S_WAIT  = 5'b00100,
		S_DRAIN = 5'b01000,
		S_ERR   = 5'b10000
	} state_t;

	// Effective dimension minus one: zero acts as one, large values clamp.
	function automatic logic [IDX_W-1:0] dim_m1(input logic [mme_pkg::DIM_REG_W-1:0] v);
		logic [mme_pkg::DIM_REG_W-1:0] e;
		if (v == '0) begin
			e = 4'd1;
		end else if (v > mme_pkg::DIM_REG_W'(MAX_DIM)) begin
			e = mme_pkg::DIM_REG_W'(MAX_DIM);
		end else begin
			e = v;
		end
		e = e - 4'd1;
		return e[IDX_W-1:0];
	endfunction

	state_t                              state_q;
	logic [mme_pkg::DIM_REG_W-1:0]       a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [IDX_W-1:0]                    ar_m1_q, ac_m1_q, bc_m1_q;
	logic [IDX_W-1:0]                    row_q, col_q, k_q;
	logic                                feed_vld_s1, feed_first_s1, feed_last_s1;
	logic [mme_pkg::FIELD_W-1:0]         feed_k_s1;
	logic signed [mme_pkg::ELEM_W-1:0]   a_rd_s1;
	logic signed [mme_pkg::ELEM_W-1:0]   mem_a [2**AW];
	logic                                out_valid_q;
	logic [mme_pkg::FIELD_W-1:0]         out_row_q, out_col_q;
	logic [mme_pkg::ACC_W-1:0]           out_val_q;
	logic                                out_last_q, out_err_q;

	logic [1:0]                          in_func;
	logic [mme_pkg::FIELD_W-1:0]         in_row, in_col;
	logic signed [mme_pkg::ELEM_W-1:0]   in_value;
	logic                                in_fire, pos_ok, a_we, ld_b;
	logic                                rd_en, out_free, drain_load, err_load;
	logic                                row_last, col_last, k_last;
	mme_pkg::bwr_t                       b_wr;
	mme_pkg::tok_t                       feed_tok;
	mme_pkg::tok_t                       tok_w [MAX_DIM];
	logic [mme_pkg::ACC_W-1:0]           acc_w [MAX_DIM];
	logic                                done_w [MAX_DIM];
	logic [MAX_DIM-1:0]                  b_we_w;

	// Input beat fields.
	assign in_func  = s_axis_tdata[1:0];
	assign in_row   = s_axis_tdata[4:2];
	assign in_col   = s_axis_tdata[7:5];
	assign in_value = s_axis_tdata[23:8];

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid & s_axis_tready;
	assign pos_ok        = ({1'b0, in_row} < (mme_pkg::FIELD_W + 1)'(MAX_DIM)) &&
	                       ({1'b0, in_col} < (mme_pkg::FIELD_W + 1)'(MAX_DIM));
	assign a_we          = in_fire && (in_func == mme_pkg::FUNC_LOAD_A) && pos_ok;
	assign ld_b          = in_fire && (in_func == mme_pkg::FUNC_LOAD_B) && pos_ok;

	assign rd_en    = (state_q == S_FEED);
	assign out_free = !out_valid_q || m_axis_tready;
	assign drain_load = (state_q == S_DRAIN) && out_free;
	assign err_load   = (state_q == S_ERR) && out_free;
	assign row_last = (row_q == ar_m1_q);
	assign col_last = (col_q == bc_m1_q);
	assign k_last   = (k_q == ac_m1_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= mme_pkg::DIM_RESET;
			a_cols_q <= mme_pkg::DIM_RESET;
			b_rows_q <= mme_pkg::DIM_RESET;
			b_cols_q <= mme_pkg::DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mme_pkg::REG_A_ROWS: a_rows_q <= cfg_data;
				mme_pkg::REG_A_COLS: a_cols_q <= cfg_data;
				mme_pkg::REG_B_ROWS: b_rows_q <= cfg_data;
				mme_pkg::REG_B_COLS: b_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Store A: one write port for loads, one registered read port for the feed.
	always_ff @(posedge clk) begin
		if (a_we) begin
			mem_a[{in_row[IDX_W-1:0], in_col[IDX_W-1:0]}] <= in_value;
		end
		if (rd_en) begin
			a_rd_s1 <= mem_a[{row_q, k_q}];
		end
	end

	// Sequencer: feed a row into the chain, wait for it, then drain it; a size mismatch sends the error beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ar_m1_q       <= '0;
			ac_m1_q       <= '0;
			bc_m1_q       <= '0;
			row_q         <= '0;
			col_q         <= '0;
			k_q           <= '0;
			feed_vld_s1   <= 1'b0;
			feed_first_s1 <= 1'b0;
			feed_last_s1  <= 1'b0;
			feed_k_s1     <= '0;
		end else begin
			feed_vld_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && (in_func == mme_pkg::FUNC_START)) begin
						ar_m1_q <= dim_m1(a_rows_q);
						ac_m1_q <= dim_m1(a_cols_q);
						bc_m1_q <= dim_m1(b_cols_q);
						row_q   <= '0;
						col_q   <= '0;
						k_q     <= '0;
						if (dim_m1(a_cols_q) != dim_m1(b_rows_q)) begin
							state_q <= S_ERR;
						end else begin
							state_q <= S_FEED;
						end
					end
				end
				S_FEED: begin
					feed_vld_s1   <= 1'b1;
					feed_first_s1 <= (k_q == '0);
					feed_last_s1  <= k_last;
					feed_k_s1     <= mme_pkg::FIELD_W'(k_q);
					if (k_last) begin
						k_q     <= '0;
						state_q <= S_WAIT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_WAIT: begin
					if (done_w[MAX_DIM-1]) begin
						col_q   <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (drain_load) begin
						if (col_last) begin
							col_q <= '0;
							if (row_last) begin
								state_q <= S_IDLE;
							end else begin
								row_q   <= row_q + 1'b1;
								state_q <= S_FEED;
							end
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				S_ERR: begin
					if (err_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Head of the cell chain.
	always_comb begin
		feed_tok.valid = feed_vld_s1;
		feed_tok.first = feed_first_s1;
		feed_tok.last  = feed_last_s1;
		feed_tok.k     = feed_k_s1;
		feed_tok.a     = a_rd_s1;
	end

	assign b_wr.row  = in_row;
	assign b_wr.data = in_value;

	// Row of cells; cell j holds column j of B and accumulates C[row][j].
	for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
		assign b_we_w[j] = ld_b && (in_col == mme_pkg::FIELD_W'(j));
		if (j == 0) begin : g_head
			mme_cell #(.MAX_DIM(MAX_DIM)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.b_we    (b_we_w[j]),
				.b_wr    (b_wr),
				.tok_in  (feed_tok),
				.tok_out (tok_w[j]),
				.acc     (acc_w[j]),
				.done    (done_w[j])
			);
		end else begin : g_body
			mme_cell #(.MAX_DIM(MAX_DIM)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.b_we    (b_we_w[j]),
				.b_wr    (b_wr),
				.tok_in  (tok_w[j-1]),
				.tok_out (tok_w[j]),
				.acc     (acc_w[j]),
				.done    (done_w[j])
			);
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (drain_load || err_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (err_load) begin
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_val_q  <= '0;
			out_last_q <= 1'b1;
			out_err_q  <= 1'b1;
		end else if (drain_load) begin
			out_row_q  <= mme_pkg::FIELD_W'(row_q);
			out_col_q  <= mme_pkg::FIELD_W'(col_q);
			out_val_q  <= acc_w[col_q];
			out_last_q <= row_last && col_last;
			out_err_q  <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_val_q, out_col_q, out_row_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_err_q;

endmodule

/* rtl/core/mme_cell.sv */
// One multiply-accumulate cell of the row; it owns one column of matrix B.
// Depends on mme_pkg for the token and B write types.
module mme_cell #(
	parameter int MAX_DIM = mme_pkg::MAX_DIM_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       b_we,
	input  mme_pkg::bwr_t              b_wr,
	input  mme_pkg::tok_t              tok_in,
	output mme_pkg::tok_t              tok_out,
	output logic [mme_pkg::ACC_W-1:0]  acc,
	output logic                       done
);

	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	logic signed [mme_pkg::ELEM_W-1:0] b_q [MAX_DIM];
	logic signed [mme_pkg::ELEM_W-1:0] b_rd;
	mme_pkg::tok_t                     tok_q;
	logic signed [mme_pkg::PROD_W-1:0] prod_s1;
	logic                              vld_s1;
	logic                              first_s1;
	logic                              last_s1;
	logic signed [mme_pkg::ACC_W-1:0]  acc_q;
	logic                              done_q;

	// Column store of B, one entry per inner index.
	always_ff @(posedge clk) begin
		if (b_we) begin
			b_q[b_wr.row[IDX_W-1:0]] <= b_wr.data;
		end
	end

	assign b_rd = b_q[tok_in.k[IDX_W-1:0]];

	// Control: token hand-off to the neighbor and the product stage flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q    <= '0;
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			tok_q    <= tok_in;
			vld_s1   <= tok_in.valid;
			first_s1 <= tok_in.first;
			last_s1  <= tok_in.last;
			done_q   <= vld_s1 & last_s1;
		end
	end

	// Multiply, then accumulate the registered product in the following cycle.
	always_ff @(posedge clk) begin
		prod_s1 <= tok_in.a * b_rd;
		if (vld_s1) begin
			if (first_s1) begin
				acc_q <= mme_pkg::ACC_W'(prod_s1);
			end else begin
				acc_q <= acc_q + mme_pkg::ACC_W'(prod_s1);
			end
		end
	end

	assign tok_out = tok_q;
	assign acc     = acc_q;
	assign done    = done_q;

endmodule

/* rtl/core/mme_checker.sv */
// Port-level checks for the matrix multiply engine, bound to the top level.
// Depends on mme_pkg for widths and function codes.
module mme_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [mme_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [mme_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic                             m_axis_tlast,
	input logic                             m_axis_tuser
);

	// A stalled output beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
		$stable(m_axis_tuser))
		else $error("output beat changed while stalled");

	// A size error beat ends the run and carries no product.
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
		else $error("size error beat not last or not zero");

	// A start beat closes the input until its run is done; this checks that ready drops.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == mme_pkg::FUNC_START)
		|=> !s_axis_tready)
		else $error("input accepted right after a start");

	// While a run still has results to come, no input is taken.
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input ready in the middle of a run");

endmodule

bind matrix_multiply_engine_top mme_checker u_mme_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

/* dv/matrix_multiply_engine_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for matrix_multiply_engine_top: directed table, then random phases.
// Depends on mme_pkg and the engine RTL; directed results are typed in the plan, random ones predicted.
module matrix_multiply_engine_top_tb;

	// Function code that the engine must ignore.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int BEAT_TARGET = 330;
	localparam int QUIET_FROM  = 280;

	typedef struct packed {
		logic [mme_pkg::FIELD_W-1:0]      row;
		logic [mme_pkg::FIELD_W-1:0]      col;
		logic signed [mme_pkg::ACC_W-1:0] value;
		logic                             last;
		logic                             size_err;
	} product_t;

	typedef enum logic {STEP_REG, STEP_BEAT} step_kind_t;

	// One row of the directed plan: a register write or an input beat.
	typedef struct packed {
		step_kind_t                       kind;
		logic [1:0]                       code;
		logic [mme_pkg::FIELD_W-1:0]      row;
		logic [mme_pkg::FIELD_W-1:0]      col;
		logic [mme_pkg::ELEM_W-1:0]       data;
		logic                             typed;
		logic signed [mme_pkg::ACC_W-1:0] want_value;
		logic                             want_err;
	} step_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_we;
	logic [1:0]                       cfg_index;
	logic [mme_pkg::DIM_REG_W-1:0]    cfg_data;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [mme_pkg::IN_TDATA_W-1:0]   s_axis_tdata;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	logic [mme_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
	logic                             m_axis_tlast;
	logic                             m_axis_tuser;

	// Testbench copy of the engine state.
	logic [mme_pkg::ELEM_W-1:0]    a_elems [64];
	logic [mme_pkg::ELEM_W-1:0]    b_elems [64];
	bit                            a_loaded [64];
	bit                            b_loaded [64];
	logic [mme_pkg::DIM_REG_W-1:0] dim_reg [4];

	product_t pending_products [$];
	int       fail_count = 0;
	int       beat_count = 0;
	bit       quiet = 1'b0;
	bit       hold_req = 1'b0;

	step_t plan [26] = '{
		'{STEP_REG,  mme_pkg::REG_A_ROWS,  3'd0, 3'd0, 16'h0000, 1'b0, 36'sd0, 1'b0},
		'{STEP_REG,  mme_pkg::REG_A_COLS,  3'd0, 3'd0, 16'h0001, 1'b0, 36'sd0, 1'b0},
		'{STEP_REG,  mme_pkg::REG_B_ROWS,  3'd0, 3'd0, 16'h0000, 1'b0, 36'sd0, 1'b0},
		'{STEP_REG,  mme_pkg::REG_B_COLS,  3'd0, 3'd0, 16'h0001, 1'b0, 36'sd0, 1'b0},
		'{STEP_BEAT, mme_pkg::FUNC_LOAD_A, 3'd7, 3'd7, 16'h7FFF, 1'b0, 36'sd0, 1'b0},
		'{STEP_BEAT, mme_pkg::FUNC_LOAD_B, 3'd7, 3'd7, 16'h8000, 1'b0, 36'sd0, 1'b0},
		'{STEP_BEAT, mme_pkg::FUNC_LOAD_A, 3'd0, 3'd0, 16'h8000, 1'b0, 36'sd0, 1'b0},
		'{STEP_BEAT, mme_pkg::FUNC_LOAD_B, 3'd0, 3'd0, 16'h8000, 1'b0, 36'sd0, 1'b0},
		'{STEP_BEAT, mme_pkg::FUNC_START,  3'd0, 3'd0, 16'h0000, 1'b1, 36'sd1073741824, 1'b0},
		'{STEP_BEAT, FUNC_UNUSED,          3'd5, 3'd2, 16'hFFFF, 1'b0, 36'sd0, 1'b0},
		'{STEP_BEAT, mme_pkg::FUNC_START,  3'd7, 3'd7, 16'hFFFF, 1'b1, 36'sd1073741824, 1'b0},
		'{STEP_BEAT, mme_pkg::FUNC_LOAD_A, 3'd0, 3'd0, 16'h7FFF, 1'b0, 36'sd0, 1'b0},
		'{STEP_BEAT, mme_pkg::FUNC_START,  3'd0, 3'd0, 16'h0000, 1'b1, -36'sd1073709056, 1'b0},
		'{STEP_BEAT, mme_pkg::FUNC_LOAD_A, 3'd0, 3'd0, 16'h0100, 1'b0, 36'sd0, 1'b0},
		'{STEP_BEAT, mme_pkg::FUNC_LOAD_B, 3'd0, 3'd0, 16'hFFFF, 1'b0, 36'sd0, 1'b0},
		'{STEP_BEAT, mme_pkg::FUNC_START,  3'd0, 3'd0, 16'h0000, 1'b1, -36'sd256, 1'b0},
		'{STEP_BEAT, mme_pkg::FUNC_LOAD_B, 3'd0, 3'd0, 16'h0000, 1'b0, 36'sd0, 1'b0},
		'{STEP_BEAT, mme_pkg::FUNC_START,  3'd0, 3'd0, 16'h0000, 1'b1, 36'sd0, 1'b0},
		'{STEP_REG,  mme_pkg::REG_A_COLS,  3'd0, 3'd0, 16'h0002, 1'b0, 36'sd0, 1'b0},
		'{STEP_REG,  mme_pkg::REG_B_ROWS,  3'd0, 3'd0, 16'h0003, 1'b0, 36'sd0, 1'b0},
		'{STEP_BEAT, mme_pkg::FUNC_START,  3'd0, 3'd0, 16'h0000, 1'b1, 36'sd0, 1'b1},
		'{STEP_REG,  mme_pkg::REG_A_COLS,  3'd0, 3'd0, 16'h000F, 1'b0, 36'sd0, 1'b0},
		'{STEP_REG,  mme_pkg::REG_B_ROWS,  3'd0, 3'd0, 16'h0007, 1'b0, 36'sd0, 1'b0},
		'{STEP_REG,  mme_pkg::REG_A_ROWS,  3'd0, 3'd0, 16'h000F, 1'b0, 36'sd0, 1'b0},
		'{STEP_REG,  mme_pkg::REG_B_COLS,  3'd0, 3'd0, 16'h000F, 1'b0, 36'sd0, 1'b0},
		'{STEP_BEAT, mme_pkg::FUNC_START,  3'd3, 3'd4, 16'h5A5A, 1'b1, 36'sd0, 1'b1}
	};

	matrix_multiply_engine_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// A dimension register value of 0 acts as 1, anything above 8 acts as 8.
	function automatic int unsigned eff_dim(input logic [mme_pkg::DIM_REG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > mme_pkg::MAX_DIM_DEFAULT)
			return mme_pkg::MAX_DIM_DEFAULT;
		return 32'(v);
	endfunction

	// Update the stores for a load, or queue the products a start will produce.
	function automatic void track_beat(input logic [1:0] f, input logic [2:0] r,
			input logic [2:0] c, input logic [mme_pkg::ELEM_W-1:0] v);
		int unsigned ar, ac, bc;
		longint acc;
		product_t p;
		case (f)
			mme_pkg::FUNC_LOAD_A: begin
				a_elems[{r, c}] = v;
				a_loaded[{r, c}] = 1'b1;
			end
			mme_pkg::FUNC_LOAD_B: begin
				b_elems[{r, c}] = v;
				b_loaded[{r, c}] = 1'b1;
			end
			mme_pkg::FUNC_START: begin
				ar = eff_dim(dim_reg[mme_pkg::REG_A_ROWS]);
				ac = eff_dim(dim_reg[mme_pkg::REG_A_COLS]);
				bc = eff_dim(dim_reg[mme_pkg::REG_B_COLS]);
				if (ac != eff_dim(dim_reg[mme_pkg::REG_B_ROWS])) begin
					p = '{row: 3'd0, col: 3'd0, value: 36'sd0, last: 1'b1, size_err: 1'b1};
					pending_products.push_back(p);
				end else begin
					for (int unsigned rr = 0; rr < ar; rr++) begin
						for (int unsigned cc = 0; cc < bc; cc++) begin
							acc = 0;
							for (int unsigned kk = 0; kk < ac; kk++)
								acc += longint'($signed(a_elems[rr * 8 + kk])) *
									longint'($signed(b_elems[kk * 8 + cc]));
							p.row      = rr[2:0];
							p.col      = cc[2:0];
							p.value    = acc[mme_pkg::ACC_W-1:0];
							p.last     = (rr + 1 == ar) && (cc + 1 == bc);
							p.size_err = 1'b0;
							pending_products.push_back(p);
						end
					end
				end
			end
			default: ;
		endcase
	endfunction

	// Element values, with the signed extremes and zero showing up often.
	function automatic logic [mme_pkg::ELEM_W-1:0] pick_elem();
		case ($urandom_range(0, 11))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly small effective dimensions, sometimes larger ones up to the largest.
	function automatic int unsigned pick_dim();
		if ($urandom_range(0, 9) < 7)
			return $urandom_range(1, 4);
		return $urandom_range(5, 8);
	endfunction

	// Register code for an effective dimension, using the out-of-range aliases at times.
	function automatic logic [mme_pkg::DIM_REG_W-1:0] dim_code(input int unsigned d);
		if (d == 1 && $urandom_range(0, 2) == 0)
			return 4'd0;
		if (d == 8 && $urandom_range(0, 1) == 0)
			return 4'($urandom_range(9, 15));
		return 4'(d);
	endfunction

	// Offer one beat, with an occasional gap in front, and wait for the handshake.
	task automatic send_beat(input logic [1:0] f, input logic [2:0] r, input logic [2:0] c,
			input logic [mme_pkg::ELEM_W-1:0] v, input bit predicted);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tdata  <= {v, c, r, f};
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (s_axis_tready !== 1'b1);
		if (predicted)
			track_beat(f, r, c, v);
		if (f != FUNC_UNUSED)
			beat_count++;
		if (beat_count >= QUIET_FROM)
			quiet = 1'b1;
	endtask

	// Stop offering beats and let the engine go idle.
	task automatic drain_outputs();
		s_axis_tvalid <= 1'b0;
		while (pending_products.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_dim(input logic [1:0] idx, input logic [mme_pkg::DIM_REG_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		dim_reg[idx] = v;
	endtask

	// One random phase: new dimensions, random loads and noise, the missing operands, a start.
	task automatic run_phase(input bit full);
		int unsigned ar, ac, br, bc, rounds;
		int unsigned sel;
		logic [2:0] r, c;
		if (full) begin
			ar = 8;
			ac = 8;
			br = 8;
			bc = 8;
		end else begin
			ar = pick_dim();
			ac = pick_dim();
			bc = pick_dim();
			br = ($urandom_range(0, 5) == 0) ? pick_dim() : ac;
		end
		drain_outputs();
		write_dim(mme_pkg::REG_A_ROWS, dim_code(ar));
		write_dim(mme_pkg::REG_A_COLS, dim_code(ac));
		write_dim(mme_pkg::REG_B_ROWS, dim_code(br));
		write_dim(mme_pkg::REG_B_COLS, dim_code(bc));
		rounds = full ? 1 : $urandom_range(1, 2);
		repeat (rounds) begin
			repeat ($urandom_range(2, 10)) begin
				sel = $urandom_range(0, 9);
				if (sel == 0) begin
					send_beat(FUNC_UNUSED, 3'($urandom), 3'($urandom), 16'($urandom), 1'b1);
				end else if (sel < 5) begin
					r = 3'($urandom_range(0, ar - 1));
					c = 3'($urandom_range(0, ac - 1));
					send_beat(mme_pkg::FUNC_LOAD_A, r, c, pick_elem(), 1'b1);
				end else if (sel < 8) begin
					r = 3'($urandom_range(0, br - 1));
					c = 3'($urandom_range(0, bc - 1));
					send_beat(mme_pkg::FUNC_LOAD_B, r, c, pick_elem(), 1'b1);
				end else begin
					send_beat(sel[0] ? mme_pkg::FUNC_LOAD_B : mme_pkg::FUNC_LOAD_A,
						3'($urandom), 3'($urandom), pick_elem(), 1'b1);
				end
			end
			// Every operand the start will read must have been written.
			if (ac == br) begin
				for (int unsigned i = 0; i < ar; i++)
					for (int unsigned k = 0; k < ac; k++)
						if (!a_loaded[i * 8 + k])
							send_beat(mme_pkg::FUNC_LOAD_A, i[2:0], k[2:0], pick_elem(),
								1'b1);
				for (int unsigned k = 0; k < ac; k++)
					for (int unsigned j = 0; j < bc; j++)
						if (!b_loaded[k * 8 + j])
							send_beat(mme_pkg::FUNC_LOAD_B, k[2:0], j[2:0], pick_elem(),
								1'b1);
			end
			send_beat(mme_pkg::FUNC_START, 3'($urandom), 3'($urandom), 16'($urandom), 1'b1);
			// Hold the output off while loads keep coming, so the engine backs up.
			if (full) begin
				hold_req = 1'b1;
				repeat (12)
					send_beat($urandom_range(0, 1) ? mme_pkg::FUNC_LOAD_B : mme_pkg::FUNC_LOAD_A,
						3'($urandom), 3'($urandom), pick_elem(), 1'b1);
			end
		end
	endtask

	// Stimulus: reset, the directed plan, then random phases.
	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = mme_pkg::REG_A_ROWS;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		foreach (dim_reg[i])
			dim_reg[i] = mme_pkg::DIM_RESET;
		foreach (a_loaded[i]) begin
			a_loaded[i] = 1'b0;
			b_loaded[i] = 1'b0;
			a_elems[i]  = '0;
			b_elems[i]  = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_REG) begin
				drain_outputs();
				write_dim(plan[i].code, plan[i].data[mme_pkg::DIM_REG_W-1:0]);
			end else begin
				send_beat(plan[i].code, plan[i].row, plan[i].col, plan[i].data, !plan[i].typed);
				if (plan[i].typed)
					pending_products.push_back('{row: 3'd0, col: 3'd0,
						value: plan[i].want_value, last: 1'b1, size_err: plan[i].want_err});
			end
		end

		run_phase(1'b1);
		while (beat_count < BEAT_TARGET)
			run_phase(1'b0);

		drain_outputs();
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Output ready: random short stalls, one long hold-off on request.
	initial begin : out_ready
		int idle_left;
		int hold_left;
		idle_left = 0;
		hold_left = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (idle_left > 0) begin
				idle_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0)
					idle_left = $urandom_range(1, 4);
			end
		end
	end

	// Compare every accepted output beat with the oldest pending product.
	always @(posedge clk) begin : product_check
		product_t seen;
		product_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.row      = m_axis_tdata[2:0];
			seen.col      = m_axis_tdata[5:3];
			seen.value    = m_axis_tdata[6 +: mme_pkg::ACC_W];
			seen.last     = m_axis_tlast;
			seen.size_err = m_axis_tuser;
			if (pending_products.size() == 0) begin
				fail_count++;
				$display("%0t: expected no beat, got row %0d col %0d value %0d last %0b err %0b",
					$time, seen.row, seen.col, seen.value, seen.last, seen.size_err);
			end else begin
				want = pending_products.pop_front();
				if (seen !== want) begin
					fail_count++;
					$display("%0t: mismatch expected row %0d col %0d value %0d last %0b err %0b, %s",
						$time, want.row, want.col, want.value, want.last, want.size_err,
						$sformatf("got row %0d col %0d value %0d last %0b err %0b",
							seen.row, seen.col, seen.value, seen.last, seen.size_err));
				end
			end
		end
	end

	// Watchdog for a hung engine.
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
